// ===== rtl/bmpt_pkg.sv =====
package bmpt_pkg;

	localparam int PACKET_BYTES = 4;

	localparam logic [1:0] CMD_START = 2'd0;
	localparam logic [1:0] CMD_RX    = 2'd1;
	localparam logic [1:0] CMD_TICK  = 2'd2;

	localparam logic [2:0] ERR_OK           = 3'd0;
	localparam logic [2:0] ERR_ECHO_TIMEOUT = 3'd1;
	localparam logic [2:0] ERR_ECHO_MISMATCH = 3'd2;
	localparam logic [2:0] ERR_REPLY_TIMEOUT = 3'd3;
	localparam logic [2:0] ERR_CHECKSUM     = 3'd4;
	localparam logic [2:0] ERR_INCOMPLETE   = 3'd5;

	localparam logic [7:0] ECHO_TIMEOUT_RESET = 8'd30;
	localparam logic [2:0] GROUP_MARK = 3'd4;

	localparam logic KIND_TX   = 1'b0;
	localparam logic KIND_DONE = 1'b1;

	// One queued job: either a whole packet to transmit or one completion.
	typedef struct packed {
		logic                          is_tx;
		logic [PACKET_BYTES-1:0][7:0]  bytes;
		logic [2:0]                    err;
		logic [7:0]                    status;
		logic [15:0]                   data;
	} job_t;

endpackage

// ===== rtl/bus_master_packet_transaction.sv =====
// Host side of a half-duplex four-byte packet bus.
// Input channel (in_valid/in_stall) carries commands: start a transaction,
// a byte received from the bus, or a one-millisecond tick. Output channel
// (out_valid/out_stall) carries transmit bytes and one done item per
// transaction with its error code, reply status and reply data.
// cfg_we/cfg_wdata set the echo timeout in ticks; it resets to 30.
// A front stage updates the protocol state in the cycle an item is taken,
// so one input item is accepted every cycle while the job queue has room.
// Jobs (a whole packet, or a completion) go through a QUEUE_DEPTH-entry
// queue to the back stage, which loads one result per cycle into the
// output register unless the receiver stalls: a start gives four transmit
// transfers, the first valid after the queue and the output register, a
// completion one transfer. Output throughput is set by the back stage,
// one result per cycle unless the receiver stalls. When it stalls, the
// output register holds; once the queue fills, in_stall rises. Reset
// empties the queue, drops the output and returns the bus state to idle.
module bus_master_packet_transaction #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [4:0]  op_code,
	input  logic        group_flag,
	input  logic [9:0]  address,
	input  logic [7:0]  payload,
	input  logic        want_reply,
	input  logic [7:0]  reply_timeout,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        kind,
	output logic [7:0]  tx_byte,
	output logic        last_byte,
	output logic [2:0]  error_code,
	output logic [7:0]  reply_status,
	output logic [15:0] reply_data
);
	import bmpt_pkg::*;

	logic accept;
	logic push;
	logic full;
	logic pop;
	logic head_valid;
	job_t push_job;
	job_t head_job;

	assign in_stall = full;
	assign accept   = in_valid && !full;

	bmpt_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.accept        (accept),
		.command       (command),
		.op_code       (op_code),
		.group_flag    (group_flag),
		.address       (address),
		.payload       (payload),
		.want_reply    (want_reply),
		.reply_timeout (reply_timeout),
		.rx_byte       (rx_byte),
		.push          (push),
		.push_job      (push_job)
	);

	bmpt_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	bmpt_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head_job     (head_job),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.kind         (kind),
		.tx_byte      (tx_byte),
		.last_byte    (last_byte),
		.error_code   (error_code),
		.reply_status (reply_status),
		.reply_data   (reply_data)
	);

endmodule

// ===== rtl/bmpt_queue.sv =====
module bmpt_queue #(
	parameter int DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  bmpt_pkg::job_t push_job,
	output logic           full,
	input  logic           pop,
	output logic           head_valid,
	output bmpt_pkg::job_t head_job
);
	import bmpt_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	job_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full       = (count_q == CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_job   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/bmpt_front.sv =====
module bmpt_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic [7:0]     cfg_wdata,
	input  logic           accept,
	input  logic [1:0]     command,
	input  logic [4:0]     op_code,
	input  logic           group_flag,
	input  logic [9:0]     address,
	input  logic [7:0]     payload,
	input  logic           want_reply,
	input  logic [7:0]     reply_timeout,
	input  logic [7:0]     rx_byte,
	output logic           push,
	output bmpt_pkg::job_t push_job
);
	import bmpt_pkg::*;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_ECHO,
		PH_REPLY
	} phase_t;

	phase_t     phase_q, phase_d;
	logic [1:0] idx_q, idx_d;
	logic [7:0] elapsed_q, elapsed_d;
	logic [7:0] sum_q, sum_d;
	logic       want_q, want_d;
	logic [7:0] limit_q, limit_d;
	logic [7:0] echo_timeout_q;

	logic [PACKET_BYTES-1:0][7:0] sent_q;
	logic [PACKET_BYTES-2:0][7:0] reply_q;
	logic                         sent_we;
	logic                         reply_we;

	logic [PACKET_BYTES-1:0][7:0] pkt;
	logic [7:0]                   tick_limit;
	logic                         busy;

	// Packet framing for a start request.
	always_comb begin
		pkt[0] = {op_code, (group_flag ? GROUP_MARK : {1'b0, address[9:8]})};
		pkt[1] = address[7:0];
		pkt[2] = payload;
		pkt[3] = {1'b0, 7'(pkt[0][6:0] + pkt[1][6:0] + pkt[2][6:0])};
	end

	assign busy       = (phase_q == PH_ECHO) || (phase_q == PH_REPLY);
	assign tick_limit = (phase_q == PH_ECHO) ? echo_timeout_q : limit_q;

	always_comb begin
		phase_d   = phase_q;
		idx_d     = idx_q;
		elapsed_d = elapsed_q;
		sum_d     = sum_q;
		want_d    = want_q;
		limit_d   = limit_q;
		sent_we   = 1'b0;
		reply_we  = 1'b0;
		push      = 1'b0;
		push_job  = '0;
		push_job.is_tx = 1'b0;

		if (accept) begin
			unique case (command)
				CMD_START: begin
					if (!busy) begin
						sent_we        = 1'b1;
						push           = 1'b1;
						push_job.is_tx = 1'b1;
						push_job.bytes = pkt;
						phase_d        = PH_ECHO;
						idx_d          = '0;
						elapsed_d      = '0;
						sum_d          = '0;
						want_d         = want_reply;
						limit_d        = reply_timeout;
					end
				end
				CMD_TICK: begin
					if (busy) begin
						if (elapsed_q == tick_limit) begin
							push      = 1'b1;
							phase_d   = PH_IDLE;
							idx_d     = '0;
							elapsed_d = '0;
							if (phase_q == PH_ECHO) begin
								push_job.err = ERR_ECHO_TIMEOUT;
							end else if (idx_q != '0) begin
								push_job.err = ERR_INCOMPLETE;
							end else begin
								push_job.err = ERR_REPLY_TIMEOUT;
							end
						end else begin
							elapsed_d = elapsed_q + 1'b1;
						end
					end
				end
				CMD_RX: begin
					if (phase_q == PH_ECHO) begin
						if (rx_byte != sent_q[idx_q]) begin
							push         = 1'b1;
							push_job.err = ERR_ECHO_MISMATCH;
							phase_d      = PH_IDLE;
							idx_d        = '0;
							elapsed_d    = '0;
						end else if (idx_q != 2'(PACKET_BYTES - 1)) begin
							idx_d = idx_q + 1'b1;
						end else if (!want_q) begin
							push         = 1'b1;
							push_job.err = ERR_OK;
							phase_d      = PH_IDLE;
							idx_d        = '0;
							elapsed_d    = '0;
						end else begin
							phase_d   = PH_REPLY;
							idx_d     = '0;
							elapsed_d = '0;
							sum_d     = '0;
						end
					end else if (phase_q == PH_REPLY) begin
						if (idx_q != 2'(PACKET_BYTES - 1)) begin
							reply_we = 1'b1;
							sum_d    = sum_q + rx_byte;
							idx_d    = idx_q + 1'b1;
						end else begin
							push      = 1'b1;
							phase_d   = PH_IDLE;
							idx_d     = '0;
							elapsed_d = '0;
							if (rx_byte[6:0] != sum_q[6:0]) begin
								push_job.err = ERR_CHECKSUM;
							end else begin
								push_job.err    = ERR_OK;
								push_job.status = reply_q[0];
								push_job.data   = {reply_q[2], reply_q[1]};
							end
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (sent_we) begin
			sent_q <= pkt;
		end
		if (reply_we) begin
			reply_q[idx_q] <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_IDLE;
			idx_q          <= '0;
			elapsed_q      <= '0;
			sum_q          <= '0;
			want_q         <= 1'b0;
			limit_q        <= '0;
			echo_timeout_q <= ECHO_TIMEOUT_RESET;
		end else begin
			phase_q   <= phase_d;
			idx_q     <= idx_d;
			elapsed_q <= elapsed_d;
			sum_q     <= sum_d;
			want_q    <= want_d;
			limit_q   <= limit_d;
			if (cfg_we) begin
				echo_timeout_q <= cfg_wdata;
			end
		end
	end

endmodule

// ===== rtl/bmpt_back.sv =====
module bmpt_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           head_valid,
	input  bmpt_pkg::job_t head_job,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_stall,
	output logic           kind,
	output logic [7:0]     tx_byte,
	output logic           last_byte,
	output logic [2:0]     error_code,
	output logic [7:0]     reply_status,
	output logic [15:0]    reply_data
);
	import bmpt_pkg::*;

	logic       out_valid_q;
	logic       kind_q;
	logic [7:0] tx_byte_q;
	logic       last_byte_q;
	logic [2:0] error_code_q;
	logic [7:0] reply_status_q;
	logic [15:0] reply_data_q;
	logic [1:0] sub_q;
	logic       load;
	logic       sub_last;

	assign load     = head_valid && (!out_valid_q || !out_stall);
	assign sub_last = (sub_q == 2'(PACKET_BYTES - 1));
	// A packet job stays at the head until its fourth byte has been loaded.
	assign pop      = load && (!head_job.is_tx || sub_last);

	always_ff @(posedge clk) begin
		if (load) begin
			if (head_job.is_tx) begin
				kind_q         <= KIND_TX;
				tx_byte_q      <= head_job.bytes[sub_q];
				last_byte_q    <= sub_last;
				error_code_q   <= ERR_OK;
				reply_status_q <= '0;
				reply_data_q   <= '0;
			end else begin
				kind_q         <= KIND_DONE;
				tx_byte_q      <= '0;
				last_byte_q    <= 1'b0;
				error_code_q   <= head_job.err;
				reply_status_q <= head_job.status;
				reply_data_q   <= head_job.data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sub_q       <= '0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (load && head_job.is_tx) begin
				sub_q <= sub_last ? '0 : sub_q + 1'b1;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = kind_q;
	assign tx_byte      = tx_byte_q;
	assign last_byte    = last_byte_q;
	assign error_code   = error_code_q;
	assign reply_status = reply_status_q;
	assign reply_data   = reply_data_q;

endmodule

// ===== sim/bus_master_packet_transaction_test.sv =====
`timescale 1ns / 100ps

module bus_master_packet_transaction_test;
	import bmpt_pkg::*;

	localparam int CLK_HALF = 10;
	localparam int ITEMS_PER_SETTING = 118;
	localparam int SETTLE_CYCLES = 16;
	localparam int HOLD_CYCLES = 400;
	localparam int LIMIT_CYCLES = 600000;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	typedef enum logic [1:0] {LINK_IDLE, LINK_ECHO, LINK_REPLY} link_phase_t;
	typedef enum int {
		TXN_CLEAN, TXN_MISMATCH, TXN_ECHO_LATE, TXN_BAD_SUM, TXN_REPLY_LATE, TXN_NOISE
	} txn_shape_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic [4:0] op_code;
		logic       group_flag;
		logic [9:0] address;
		logic [7:0] payload;
		logic       want_reply;
		logic [7:0] reply_timeout;
		logic [7:0] rx_byte;
	} bus_item_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  tx;
		logic        last;
		logic [2:0]  err;
		logic [7:0]  status;
		logic [15:0] data;
	} bus_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [7:0]  cfg_wdata = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  command = '0;
	logic [4:0]  op_code = '0;
	logic        group_flag = 1'b0;
	logic [9:0]  address = '0;
	logic [7:0]  payload = '0;
	logic        want_reply = 1'b0;
	logic [7:0]  reply_timeout = '0;
	logic [7:0]  rx_byte = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        kind;
	logic [7:0]  tx_byte;
	logic        last_byte;
	logic [2:0]  error_code;
	logic [7:0]  reply_status;
	logic [15:0] reply_data;

	bus_master_packet_transaction dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.command(command),
		.op_code(op_code),
		.group_flag(group_flag),
		.address(address),
		.payload(payload),
		.want_reply(want_reply),
		.reply_timeout(reply_timeout),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind(kind),
		.tx_byte(tx_byte),
		.last_byte(last_byte),
		.error_code(error_code),
		.reply_status(reply_status),
		.reply_data(reply_data)
	);

	// Shadow of the bus state, advanced once per accepted input transfer.
	link_phase_t     link_phase = LINK_IDLE;
	logic [7:0]      echo_limit = ECHO_TIMEOUT_RESET;
	logic [3:0][7:0] sent_bytes = '0;
	logic [1:0]      byte_count = '0;
	logic [7:0]      elapsed = '0;
	logic [7:0]      reply_sum = '0;
	logic [2:0][7:0] reply_bytes = '0;
	logic            reply_wanted = 1'b0;
	logic [7:0]      reply_limit = '0;

	bus_item_t   pending_items[$];
	bus_result_t expected_results[$];
	bus_item_t   cur_item;
	logic        send_valid;
	int          in_wait = 0;
	int          out_wait = 0;
	int          in_gap_max = 18;
	int          out_gap_max = 18;
	int          hold_requests = 0;
	int          holds_served = 0;
	int          hold_left = 0;
	int          queued_count = 0;
	int          inputs_accepted = 0;
	int          outputs_checked = 0;
	int          mismatches = 0;
	int          settings_written = 0;
	int          done_by_error [0:7] = '{default: 0};

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	function automatic logic [3:0][7:0] frame_packet(input bus_item_t it);
		logic [3:0][7:0] pkt;
		logic [7:0]      sum;
		pkt[0] = {it.op_code, it.group_flag ? GROUP_MARK : {1'b0, it.address[9:8]}};
		pkt[1] = it.address[7:0];
		pkt[2] = it.payload;
		sum = pkt[0] + pkt[1] + pkt[2];
		pkt[3] = {1'b0, sum[6:0]};
		return pkt;
	endfunction

	function automatic bus_item_t random_item(input logic [1:0] cmd);
		bus_item_t it;
		it.cmd = cmd;
		it.op_code = 5'($urandom_range(0, 31));
		it.group_flag = 1'($urandom_range(0, 1));
		it.address = 10'($urandom_range(0, 1023));
		it.payload = 8'($urandom_range(0, 255));
		it.want_reply = 1'($urandom_range(0, 1));
		it.reply_timeout = 8'($urandom_range(1, 255));
		it.rx_byte = 8'($urandom_range(0, 255));
		return it;
	endfunction

	function automatic bus_item_t rx_item(input logic [7:0] b);
		bus_item_t it;
		it = random_item(CMD_RX);
		it.rx_byte = b;
		return it;
	endfunction

	function automatic int draw_wait(input int max_n);
		return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, max_n);
	endfunction

	task automatic post_result(input logic k, input logic [7:0] tx, input logic last,
			input logic [2:0] err, input logic [7:0] status, input logic [15:0] data);
		bus_result_t r;
		r.kind = k;
		r.tx = tx;
		r.last = last;
		r.err = err;
		r.status = status;
		r.data = data;
		expected_results.push_back(r);
	endtask

	task automatic close_transaction(input logic [2:0] err, input logic [7:0] status,
			input logic [15:0] data);
		link_phase = LINK_IDLE;
		byte_count = '0;
		elapsed = '0;
		post_result(KIND_DONE, 8'd0, 1'b0, err, status, data);
	endtask

	task automatic advance_bus_state(input bus_item_t it);
		logic [7:0] limit;
		int         i;
		if (it.cmd == CMD_START) begin
			if (link_phase != LINK_IDLE)
				return;
			sent_bytes = frame_packet(it);
			for (i = 0; i < PACKET_BYTES; i++)
				post_result(KIND_TX, sent_bytes[i], i == PACKET_BYTES - 1, ERR_OK, 8'd0, 16'd0);
			link_phase = LINK_ECHO;
			byte_count = '0;
			elapsed = '0;
			reply_sum = '0;
			reply_wanted = it.want_reply;
			reply_limit = it.reply_timeout;
		end else if (link_phase == LINK_IDLE || it.cmd == CMD_UNUSED) begin
			return;
		end else if (it.cmd == CMD_TICK) begin
			limit = (link_phase == LINK_ECHO) ? echo_limit : reply_limit;
			if (elapsed != limit)
				elapsed = elapsed + 8'd1;
			else if (link_phase == LINK_ECHO)
				close_transaction(ERR_ECHO_TIMEOUT, 8'd0, 16'd0);
			else
				close_transaction(byte_count != 0 ? ERR_INCOMPLETE : ERR_REPLY_TIMEOUT,
					8'd0, 16'd0);
		end else if (link_phase == LINK_ECHO) begin
			if (it.rx_byte != sent_bytes[byte_count]) begin
				close_transaction(ERR_ECHO_MISMATCH, 8'd0, 16'd0);
			end else if (byte_count != 2'd3) begin
				byte_count = byte_count + 2'd1;
			end else if (!reply_wanted) begin
				close_transaction(ERR_OK, 8'd0, 16'd0);
			end else begin
				link_phase = LINK_REPLY;
				byte_count = '0;
				elapsed = '0;
				reply_sum = '0;
			end
		end else begin
			if (byte_count != 2'd3) begin
				reply_bytes[byte_count] = it.rx_byte;
				reply_sum = reply_sum + it.rx_byte;
				byte_count = byte_count + 2'd1;
			end else if (it.rx_byte[6:0] != reply_sum[6:0]) begin
				close_transaction(ERR_CHECKSUM, 8'd0, 16'd0);
			end else begin
				close_transaction(ERR_OK, reply_bytes[0], {reply_bytes[2], reply_bytes[1]});
			end
		end
	endtask

	// Sender: one item at a time from the pending queue, with a random gap after each transfer.
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			send_valid = in_valid;
			if (in_valid && !in_stall) begin
				advance_bus_state(cur_item);
				inputs_accepted++;
				send_valid = 1'b0;
				in_wait = draw_wait(in_gap_max);
			end else if (!in_valid && in_wait != 0) begin
				in_wait--;
			end
			if (!send_valid && in_wait == 0 && pending_items.size() != 0) begin
				cur_item = pending_items.pop_front();
				command <= cur_item.cmd;
				op_code <= cur_item.op_code;
				group_flag <= cur_item.group_flag;
				address <= cur_item.address;
				payload <= cur_item.payload;
				want_reply <= cur_item.want_reply;
				reply_timeout <= cur_item.reply_timeout;
				rx_byte <= cur_item.rx_byte;
				send_valid = 1'b1;
			end
			in_valid <= send_valid;
		end
	end

	// Long receiver hold-off, so the job queue fills and the input side backs up.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (holds_served != hold_requests) begin
			hold_left <= HOLD_CYCLES;
			holds_served <= holds_served + 1;
		end
	end

	task automatic check_result();
		bus_result_t want;
		if (expected_results.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: unexpected output transfer kind %0d tx %02h err %0d",
					$realtime, kind, tx_byte, error_code);
			return;
		end
		want = expected_results.pop_front();
		outputs_checked++;
		if (want.kind == KIND_DONE)
			done_by_error[want.err]++;
		if (kind !== want.kind || tx_byte !== want.tx || last_byte !== want.last ||
				error_code !== want.err || reply_status !== want.status ||
				reply_data !== want.data) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("%0t: expected kind %0d tx %02h last %0d err %0d status %02h data %04h",
					$realtime, want.kind, want.tx, want.last, want.err, want.status, want.data);
				$display("%0t:      got kind %0d tx %02h last %0d err %0d status %02h data %04h",
					$realtime, kind, tx_byte, last_byte, error_code, reply_status, reply_data);
			end
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				check_result();
				out_wait = draw_wait(out_gap_max);
			end else if (out_wait != 0) begin
				out_wait--;
			end
			out_stall <= (out_wait != 0) || (hold_left != 0);
		end
	end

	task automatic push_item(input bus_item_t it);
		pending_items.push_back(it);
		queued_count++;
	endtask

	// Scripted traffic now and then gets a stray item slipped in ahead of it.
	task automatic push_scripted(input bus_item_t it);
		if ($urandom_range(0, 39) == 0)
			push_item(random_item(2'($urandom_range(0, 3))));
		push_item(it);
	endtask

	task automatic queue_transaction();
		bus_item_t       start_item;
		logic [3:0][7:0] pkt;
		logic [2:0][7:0] reply;
		logic [7:0]      sum;
		txn_shape_t      shape;
		int              pick, count, tick_budget, ticks_used, i;
		pick = $urandom_range(0, 15);
		if (pick < 8)
			shape = TXN_CLEAN;
		else if (pick < 10)
			shape = TXN_MISMATCH;
		else if (pick < 11)
			shape = TXN_ECHO_LATE;
		else if (pick < 12)
			shape = TXN_BAD_SUM;
		else if (pick < 14)
			shape = TXN_REPLY_LATE;
		else
			shape = TXN_NOISE;
		if (shape == TXN_ECHO_LATE && echo_limit > 8'd40)
			shape = TXN_CLEAN;
		if (shape == TXN_NOISE) begin
			repeat ($urandom_range(1, 3))
				push_item(random_item(2'($urandom_range(0, 3))));
			return;
		end

		start_item = random_item(CMD_START);
		if (shape == TXN_BAD_SUM || shape == TXN_REPLY_LATE)
			start_item.want_reply = 1'b1;
		if (shape == TXN_REPLY_LATE)
			start_item.reply_timeout = 8'($urandom_range(1, 4));
		pkt = frame_packet(start_item);
		push_scripted(start_item);

		// Echo, with a few ticks that stay inside the echo timeout.
		count = (shape == TXN_MISMATCH || shape == TXN_ECHO_LATE) ?
			$urandom_range(0, PACKET_BYTES - 1) : PACKET_BYTES;
		tick_budget = (echo_limit < 8'd2) ? echo_limit : 2;
		ticks_used = 0;
		for (i = 0; i < count; i++) begin
			if (ticks_used < tick_budget && $urandom_range(0, 2) == 0) begin
				push_scripted(random_item(CMD_TICK));
				ticks_used++;
			end
			push_scripted(rx_item(pkt[i]));
		end
		if (shape == TXN_MISMATCH) begin
			push_scripted(rx_item(pkt[count] ^ 8'($urandom_range(1, 255))));
			return;
		end
		if (shape == TXN_ECHO_LATE) begin
			repeat (int'(echo_limit) + 1 - ticks_used)
				push_scripted(random_item(CMD_TICK));
			return;
		end
		if (!start_item.want_reply)
			return;

		for (i = 0; i < PACKET_BYTES - 1; i++)
			reply[i] = 8'($urandom_range(0, 255));
		if (shape == TXN_REPLY_LATE) begin
			count = $urandom_range(0, PACKET_BYTES - 1);
			for (i = 0; i < count; i++)
				push_scripted(rx_item(reply[i]));
			repeat (int'(start_item.reply_timeout) + 1)
				push_scripted(random_item(CMD_TICK));
			return;
		end
		tick_budget = (start_item.reply_timeout < 8'd2) ? start_item.reply_timeout : 2;
		ticks_used = 0;
		sum = '0;
		for (i = 0; i < PACKET_BYTES - 1; i++) begin
			if (ticks_used < tick_budget && $urandom_range(0, 2) == 0) begin
				push_scripted(random_item(CMD_TICK));
				ticks_used++;
			end
			push_scripted(rx_item(reply[i]));
			sum = sum + reply[i];
		end
		if (shape == TXN_BAD_SUM)
			push_scripted(rx_item({1'($urandom_range(0, 1)),
				sum[6:0] ^ 7'($urandom_range(1, 127))}));
		else
			push_scripted(rx_item({1'($urandom_range(0, 1)), sum[6:0]}));
	endtask

	// Returns at a falling edge once every transfer is sent and every result has come back.
	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_items.size() != 0 || in_valid || expected_results.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Times out whatever transaction is still open so the bus is idle.
	task automatic settle_bus();
		int n;
		wait_drained();
		while (link_phase != LINK_IDLE) begin
			n = int'((link_phase == LINK_ECHO) ? echo_limit : reply_limit) - int'(elapsed) + 1;
			repeat (n) push_item(random_item(CMD_TICK));
			wait_drained();
		end
	endtask

	task automatic write_echo_limit(input logic [7:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		echo_limit = value;
		settings_written++;
		@(negedge clk);
	endtask

	task automatic run_setting(input logic [7:0] limit, input int in_max, input int out_max,
			input logic with_hold);
		int goal;
		write_echo_limit(limit);
		in_gap_max = in_max;
		out_gap_max = out_max;
		if (with_hold)
			hold_requests++;
		goal = queued_count + ITEMS_PER_SETTING;
		while (queued_count < goal)
			queue_transaction();
		settle_bus();
	endtask

	initial begin
		#(LIMIT_CYCLES * 2 * CLK_HALF);
		$display("Timed out with %0d results still expected", expected_results.size());
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		bus_item_t       it;
		logic [3:0][7:0] pkt;
		int              i;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Traffic while idle is dropped.
		push_item(random_item(CMD_RX));
		push_item(random_item(CMD_TICK));
		push_item(random_item(CMD_UNUSED));

		// All-ones fields with group addressing, no reply.
		it = random_item(CMD_START);
		it.op_code = '1;
		it.group_flag = 1'b1;
		it.address = '1;
		it.payload = '1;
		it.want_reply = 1'b0;
		it.reply_timeout = '1;
		push_item(it);
		pkt = frame_packet(it);
		for (i = 0; i < PACKET_BYTES; i++)
			push_item(rx_item(pkt[i]));

		// Zero fields with high address bits and a reply; a second start and an unused
		// command are ignored while the bus is busy.
		it = random_item(CMD_START);
		it.op_code = '0;
		it.group_flag = 1'b0;
		it.address = 10'h300;
		it.payload = '0;
		it.want_reply = 1'b1;
		it.reply_timeout = 8'd255;
		push_item(it);
		pkt = frame_packet(it);
		push_item(random_item(CMD_START));
		push_item(random_item(CMD_UNUSED));
		for (i = 0; i < PACKET_BYTES; i++)
			push_item(rx_item(pkt[i]));
		push_item(rx_item(8'hff));
		push_item(rx_item(8'h00));
		push_item(rx_item(8'hff));
		push_item(rx_item(8'hfe));

		// The very first echo byte comes back wrong.
		it = random_item(CMD_START);
		it.want_reply = 1'b0;
		push_item(it);
		pkt = frame_packet(it);
		push_item(rx_item(~pkt[0]));
		settle_bus();

		run_setting(8'd1, 18, 18, 1'b0);
		run_setting(8'd255, 18, 0, 1'b0);
		run_setting(8'($urandom_range(2, 254)), 0, 18, 1'b1);
		run_setting(8'($urandom_range(2, 6)), 18, 18, 1'b0);

		if (expected_results.size() != 0) begin
			$display("%0d expected results never arrived", expected_results.size());
			mismatches += expected_results.size();
		end
		$display("Sent %0d input transfers, checked %0d output transfers, %0d echo timeout settings.",
			inputs_accepted, outputs_checked, settings_written + 1);
		$display("Closed: %0d ok, %0d echo timeout, %0d echo mismatch, %0d reply timeout, %0d %s",
			done_by_error[ERR_OK], done_by_error[ERR_ECHO_TIMEOUT],
			done_by_error[ERR_ECHO_MISMATCH], done_by_error[ERR_REPLY_TIMEOUT],
			done_by_error[ERR_CHECKSUM], "bad checksum");
		$display("        %0d incomplete reply; %0d mismatches", done_by_error[ERR_INCOMPLETE],
			mismatches);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/bmpt_pkg.sv
rtl/bmpt_queue.sv
rtl/bmpt_front.sv
rtl/bmpt_back.sv
rtl/bus_master_packet_transaction.sv
sim/bus_master_packet_transaction_test.sv
